// File: rtl/alle_pkg.sv
`default_nettype none

package alle_pkg;

    localparam int NODES  = 64;
    localparam int IDX_W  = $clog2(NODES);
    localparam int USED_W = $clog2(NODES + 1);
    localparam int LINK_W = 7;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;

    localparam logic [LINK_W-1:0] NULL_LINK = 7'd127;

    typedef enum logic [1:0] {
        CMD_INS_HEAD  = 2'd0,
        CMD_INS_AFTER = 2'd1,
        CMD_DELETE    = 2'd2,
        CMD_DUMP      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_POS,
        OP_RD_HEAD,
        OP_RD_LINK,
        OP_RD_TMP,
        OP_INS_HEAD,
        OP_INS_NEW,
        OP_INS_FIX,
        OP_DEL_HEAD,
        OP_DEL_FIX,
        OP_DUMP_START,
        OP_DUMP_EMIT,
        OP_STATUS
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic pos_zero;
        logic pos_bad;
        logic full;
        logic head_ok;
        logic link_ok;
        logic tmp_ok;
        logic dump_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/alle_if.sv
`default_nettype none

interface alle_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic [alle_pkg::POS_W-1:0] position;
    logic signed [alle_pkg::VAL_W-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface alle_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic signed [alle_pkg::VAL_W-1:0] item_value;
    logic                      last;

    modport source (output valid, status, item_value, last, input ready);
    modport sink   (input valid, status, item_value, last, output ready);
endinterface

`default_nettype wire

// File: rtl/alle_ctrl.sv
`default_nettype none

module alle_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire alle_pkg::dp_stat_t stat,
    output alle_pkg::dp_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_NEW,
        S_INS_FIX,
        S_DEL_HEAD,
        S_DEL_CHK,
        S_DEL_FIX,
        S_DUMP_RD,
        S_DUMP_EMIT,
        S_RESP
    } state_t;

    state_t                state_reg, state_next;
    alle_pkg::status_t     resp_reg, resp_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        resp_next  = resp_reg;
        cmd.op     = alle_pkg::OP_NONE;
        cmd.code   = resp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = alle_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                case (stat.cmd)
                    alle_pkg::CMD_INS_HEAD:
                    begin
                        if (stat.full)
                        begin
                            resp_next = alle_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.op    = alle_pkg::OP_INS_HEAD;
                            resp_next = alle_pkg::ST_OK;
                        end
                    end
                    alle_pkg::CMD_INS_AFTER:
                    begin
                        // position is checked before fullness
                        if (stat.pos_zero || stat.pos_bad)
                        begin
                            resp_next = alle_pkg::ST_BAD;
                        end
                        else if (stat.full)
                        begin
                            resp_next = alle_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.op     = alle_pkg::OP_RD_POS;
                            state_next = S_INS_NEW;
                        end
                    end
                    alle_pkg::CMD_DELETE:
                    begin
                        if (stat.pos_zero)
                        begin
                            if (!stat.head_ok)
                            begin
                                resp_next = alle_pkg::ST_BAD;
                            end
                            else
                            begin
                                cmd.op     = alle_pkg::OP_RD_HEAD;
                                state_next = S_DEL_HEAD;
                            end
                        end
                        else if (stat.pos_bad)
                        begin
                            resp_next = alle_pkg::ST_BAD;
                        end
                        else
                        begin
                            cmd.op     = alle_pkg::OP_RD_POS;
                            state_next = S_DEL_CHK;
                        end
                    end
                    default:
                    begin
                        cmd.op     = alle_pkg::OP_DUMP_START;
                        state_next = S_DUMP_RD;
                    end
                endcase
            end
            S_INS_NEW:
            begin
                cmd.op     = alle_pkg::OP_INS_NEW;
                state_next = S_INS_FIX;
            end
            S_INS_FIX:
            begin
                cmd.op     = alle_pkg::OP_INS_FIX;
                resp_next  = alle_pkg::ST_OK;
                state_next = S_RESP;
            end
            S_DEL_HEAD:
            begin
                cmd.op     = alle_pkg::OP_DEL_HEAD;
                resp_next  = alle_pkg::ST_OK;
                state_next = S_RESP;
            end
            S_DEL_CHK:
            begin
                if (!stat.link_ok)
                begin
                    resp_next  = alle_pkg::ST_BAD;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op     = alle_pkg::OP_RD_LINK;
                    state_next = S_DEL_FIX;
                end
            end
            S_DEL_FIX:
            begin
                cmd.op     = alle_pkg::OP_DEL_FIX;
                resp_next  = alle_pkg::ST_OK;
                state_next = S_RESP;
            end
            S_DUMP_RD:
            begin
                // only an empty list gets here with no valid node
                if (!stat.tmp_ok)
                begin
                    resp_next  = alle_pkg::ST_BAD;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op     = alle_pkg::OP_RD_TMP;
                    state_next = S_DUMP_EMIT;
                end
            end
            S_DUMP_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = alle_pkg::OP_DUMP_EMIT;
                    state_next = stat.dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = alle_pkg::OP_STATUS;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            resp_reg  <= alle_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/alle_datapath.sv
`default_nettype none

module alle_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [1:0]                   req_command,
    input  wire logic [alle_pkg::POS_W-1:0]   req_position,
    input  wire logic [alle_pkg::VAL_W-1:0]   req_value,
    input  wire alle_pkg::dp_cmd_t            cmd,
    output alle_pkg::dp_stat_t                stat,
    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output logic [1:0]                        rsp_status,
    output logic [alle_pkg::VAL_W-1:0]        rsp_item_value,
    output logic                              rsp_last
);

    localparam int IDX_W  = alle_pkg::IDX_W;
    localparam int USED_W = alle_pkg::USED_W;
    localparam int LINK_W = alle_pkg::LINK_W;
    localparam int VAL_W  = alle_pkg::VAL_W;
    localparam logic [LINK_W-1:0] NODE_LIM = LINK_W'(alle_pkg::NODES);

    logic [VAL_W-1:0]  node_value [alle_pkg::NODES];
    logic [LINK_W-1:0] node_link  [alle_pkg::NODES];

    alle_pkg::cmd_t               cmd_reg;
    logic [alle_pkg::POS_W-1:0]   pos_reg;
    logic [VAL_W-1:0]             val_reg;
    logic [LINK_W-1:0]            head_reg;
    logic [USED_W-1:0]            used_reg;
    logic [LINK_W-1:0]            tmp_reg;
    logic [USED_W-1:0]            cnt_reg;
    logic [LINK_W-1:0]            rd_link_reg;
    logic [VAL_W-1:0]             rd_value_reg;

    logic                         out_valid_reg;
    alle_pkg::status_t            out_status_reg;
    logic [VAL_W-1:0]             out_value_reg;
    logic                         out_last_reg;

    logic [IDX_W-1:0]  pos_idx;
    logic [IDX_W-1:0]  used_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_en;
    logic              val_we;
    logic              link_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_link;
    logic              out_free;

    assign pos_idx  = IDX_W'(pos_reg - 7'd1);
    assign used_idx = used_reg[IDX_W-1:0];
    assign out_free = !out_valid_reg || rsp_ready;

    assign stat.cmd       = cmd_reg;
    assign stat.pos_zero  = (pos_reg == '0);
    assign stat.pos_bad   = (pos_reg > alle_pkg::POS_W'(used_reg));
    assign stat.full      = (used_reg == USED_W'(alle_pkg::NODES));
    assign stat.head_ok   = (head_reg < NODE_LIM);
    assign stat.link_ok   = (rd_link_reg < NODE_LIM);
    assign stat.tmp_ok    = (tmp_reg < NODE_LIM);
    assign stat.dump_last = (rd_link_reg >= NODE_LIM) ||
                            (cnt_reg == USED_W'(alle_pkg::NODES - 1));
    assign stat.out_free  = out_free;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = head_reg[IDX_W-1:0];
        val_we  = 1'b0;
        link_we = 1'b0;
        wr_addr = used_idx;
        wr_link = head_reg;
        case (cmd.op)
            alle_pkg::OP_RD_POS:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_idx;
            end
            alle_pkg::OP_RD_HEAD:
            begin
                rd_en   = 1'b1;
                rd_addr = head_reg[IDX_W-1:0];
            end
            alle_pkg::OP_RD_LINK:
            begin
                rd_en   = 1'b1;
                rd_addr = rd_link_reg[IDX_W-1:0];
            end
            alle_pkg::OP_RD_TMP:
            begin
                rd_en   = 1'b1;
                rd_addr = tmp_reg[IDX_W-1:0];
            end
            alle_pkg::OP_INS_HEAD:
            begin
                val_we  = 1'b1;
                link_we = 1'b1;
                wr_addr = used_idx;
                wr_link = head_reg;
            end
            alle_pkg::OP_INS_NEW:
            begin
                // new node takes over the successor of node k
                val_we  = 1'b1;
                link_we = 1'b1;
                wr_addr = used_idx;
                wr_link = rd_link_reg;
            end
            alle_pkg::OP_INS_FIX:
            begin
                link_we = 1'b1;
                wr_addr = pos_idx;
                wr_link = LINK_W'(used_reg);
            end
            alle_pkg::OP_DEL_FIX:
            begin
                // skip over the removed successor
                link_we = 1'b1;
                wr_addr = pos_idx;
                wr_link = rd_link_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            node_value[wr_addr] <= val_reg;
        end
        if (link_we)
        begin
            node_link[wr_addr] <= wr_link;
        end
        if (rd_en)
        begin
            rd_link_reg  <= node_link[rd_addr];
            rd_value_reg <= node_value[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == alle_pkg::OP_LOAD)
        begin
            cmd_reg <= alle_pkg::cmd_t'(req_command);
            pos_reg <= req_position;
            val_reg <= req_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= alle_pkg::NULL_LINK;
            used_reg <= '0;
            tmp_reg  <= alle_pkg::NULL_LINK;
            cnt_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                alle_pkg::OP_INS_HEAD:
                begin
                    head_reg <= LINK_W'(used_reg);
                    used_reg <= used_reg + 1'b1;
                end
                alle_pkg::OP_INS_FIX:
                begin
                    used_reg <= used_reg + 1'b1;
                end
                alle_pkg::OP_DEL_HEAD:
                begin
                    head_reg <= rd_link_reg;
                end
                alle_pkg::OP_DUMP_START:
                begin
                    tmp_reg <= head_reg;
                    cnt_reg <= '0;
                end
                alle_pkg::OP_DUMP_EMIT:
                begin
                    tmp_reg <= rd_link_reg;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                default:
                begin
                    tmp_reg <= tmp_reg;
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == alle_pkg::OP_DUMP_EMIT || cmd.op == alle_pkg::OP_STATUS)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == alle_pkg::OP_DUMP_EMIT)
        begin
            out_status_reg <= alle_pkg::ST_OK;
            out_value_reg  <= rd_value_reg;
            out_last_reg   <= stat.dump_last;
        end
        else if (cmd.op == alle_pkg::OP_STATUS)
        begin
            out_status_reg <= cmd.code;
            out_value_reg  <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_status     = out_status_reg;
    assign rsp_item_value = out_value_reg;
    assign rsp_last       = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/array_linked_list_engine.sv
// insert at head, insert after node and delete each end in one status word, loaded into the
// output register once it is free; only one command is worked at a time
// dump: one word per value, each from a node memory read, then an output register load
// (the load waits while the output register holds a word); the next command is taken once
// the last word is in the output register, while that word may still wait
// reset: asynchronous, active low; list empty, pool count zero, no node memory clear
`default_nettype none

module array_linked_list_engine (
    input  wire logic clk,
    input  wire logic rst_n,
    alle_req_if.sink  req,
    alle_rsp_if.source rsp
);

    alle_pkg::dp_cmd_t  cmd;
    alle_pkg::dp_stat_t stat;

    alle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    alle_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_command    (req.command),
        .req_position   (req.position),
        .req_value      (req.value),
        .cmd            (cmd),
        .stat           (stat),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_status     (rsp.status),
        .rsp_item_value (rsp.item_value),
        .rsp_last       (rsp.last)
    );

endmodule

`default_nettype wire

// File: rtl/alle_checker.sv
`default_nettype none

module alle_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    input  wire logic                       req_ready,
    input  wire logic                       rsp_valid,
    input  wire logic                       rsp_ready,
    input  wire logic [1:0]                 rsp_status,
    input  wire logic [alle_pkg::VAL_W-1:0] rsp_item_value,
    input  wire logic                       rsp_last
);

    // a held word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped while stalled");

    // a held word keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(rsp_status) && $stable(rsp_item_value) && $stable(rsp_last))
        else $error("rsp payload changed while stalled");

    // one command at a time: no word taken right after a word
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req taken back to back");

    // a failing status is a lone word with no value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != alle_pkg::ST_OK |-> rsp_last && rsp_item_value == '0)
        else $error("error status word not final or carries a value");

endmodule

bind array_linked_list_engine alle_checker u_alle_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_item_value (rsp.item_value),
    .rsp_last       (rsp.last)
);

`default_nettype wire
